>>> rtl/codel_drop_decision_assert.svh
// Assertion macros shared by the CoDel drop decision RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef CODEL_DROP_DECISION_ASSERT_SVH
`define CODEL_DROP_DECISION_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset
`define CDD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CDD_ASSERT(label, clk, rst_n, prop, msg)
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/cdd_pkg.sv
// Types and constants for the CoDel drop decision block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package cdd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET      = 2'd0;
    localparam logic [1:0] CFG_INTERVAL    = 2'd1;
    localparam logic [1:0] CFG_MIN_BACKLOG = 2'd2;

    // Configuration reset values
    localparam logic [47:0] TARGET_RESET      = 48'd100000;
    localparam logic [47:0] INTERVAL_RESET    = 48'd2000000;
    localparam logic [15:0] MIN_BACKLOG_RESET = 16'd1514;

    // 3.0 in the Q32.32 form used by the Newton step
    localparam logic [63:0] NEWTON_THREE = 64'h0000_0003_0000_0000;
    // Recent-drop window is sixteen intervals
    localparam int unsigned DROP_WINDOW_SHIFT = 4;
    // Inverse root of a count of one (all ones fraction)
    localparam logic [31:0] U32_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        VERDICT_DELIVER = 2'd0,
        VERDICT_DROP    = 2'd1,
        VERDICT_EMPTY   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        FU_NONE  = 2'd0,
        FU_ENTRY = 2'd1,
        FU_LOOP  = 2'd2
    } t_follow_up;

    typedef struct packed {
        logic        queue_empty;
        logic [47:0] sojourn_ticks;
        logic [31:0] backlog_bytes;
        logic [63:0] now_ticks;
    } t_in_word;

    typedef struct packed {
        t_verdict    verdict;
        logic        in_drop_mode;
        logic [31:0] drop_count;
    } t_out_word;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_EVAL,
        OP_EMPTY,
        OP_LEAVE,
        OP_CLR_FU,
        OP_ENTER,
        OP_STEP_DROP,
        OP_NW_XX,
        OP_NW_CX2,
        OP_NW_V,
        OP_NW_VLO,
        OP_NW_VHI,
        OP_NW_FIN,
        OP_CL_LO,
        OP_CL_HI,
        OP_CL_FIN,
        OP_CMP,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   cl_from_now;
    } t_dp_cmd;

    typedef struct packed {
        logic       queue_empty;
        logic       above;
        logic       recent;
        logic       ge_next;
        logic       dropping;
        t_follow_up follow_up;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_NW_XX,
        S_NW_CX2,
        S_NW_V,
        S_NW_VLO,
        S_NW_VHI,
        S_NW_FIN,
        S_CL_LO,
        S_CL_HI,
        S_CL_FIN,
        S_CMP,
        S_RECHECK,
        S_DONE
    } t_ctrl_state;

endpackage

`default_nettype wire

>>> rtl/cdd_datapath.sv
// Datapath of the CoDel drop decision: CoDel state, config registers,
// shared 32x32 multiplier, output word register. Depends on cdd_pkg.
`default_nettype none
`include "codel_drop_decision_assert.svh"

module cdd_datapath
    import cdd_pkg::*;
#(
    parameter int unsigned RECIP_SQRT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire t_in_word    i_in_data,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    output t_out_word        o_out_data
);

    localparam int unsigned INV_SHIFT = 32 - RECIP_SQRT_BITS;
    localparam int unsigned INV_LSB   = 63 - RECIP_SQRT_BITS;

    // Configuration
    logic [47:0] r_target;
    logic [47:0] r_interval;
    logic [15:0] r_min_backlog;

    // CoDel state
    logic                       r_dropping;
    logic [63:0]                r_first_above;
    logic [63:0]                r_next_drop;
    logic [31:0]                r_cnt;
    logic [31:0]                r_last;
    logic [RECIP_SQRT_BITS-1:0] r_inv;
    t_follow_up                 r_follow_up;
    t_verdict                   r_verdict;
    logic                       r_above;
    logic                       r_recent;
    logic                       r_ge;

    // Working registers
    t_in_word    r_in;
    logic [63:0] r_prod;
    logic [61:0] r_v;
    logic [63:0] r_acc;
    t_out_word   r_out;

    logic [31:0] x_q32;
    logic        below;
    logic        now_after_fa;
    logic [63:0] fa_armed;
    logic [63:0] since_next;
    logic [63:0] drop_window;
    logic        ge_next;
    logic [31:0] cnt_enter;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;
    logic [63:0] mul_p;
    logic [63:0] v_next;
    logic [63:0] inv_full;
    logic [63:0] cl_base;
    logic [63:0] cl_part;
    logic [63:0] cl_sum;

    // Inverse root scaled up to Q0.32
    assign x_q32 = 32'(r_inv) << INV_SHIFT;

    // Above-target and drop-window tests on the captured word
    assign below        = (r_in.sojourn_ticks < r_target)
                       || (r_in.backlog_bytes <= 32'(r_min_backlog));
    assign now_after_fa = r_in.now_ticks > r_first_above;
    assign fa_armed     = r_in.now_ticks + 64'(r_interval);
    assign since_next   = r_in.now_ticks - r_next_drop;
    assign drop_window  = 64'(r_interval) << DROP_WINDOW_SHIFT;
    assign ge_next      = r_in.now_ticks >= r_next_drop;

    // Count on entering dropping mode
    assign cnt_enter = r_recent ? ((r_cnt - r_last) | 32'd1) : 32'd1;

    // Select multiplier operands
    always_comb begin
        mul_a  = x_q32;
        mul_b  = x_q32;
        mul_en = 1'b1;
        case (i_cmd.op)
            OP_NW_XX: begin
                mul_a = x_q32;
            end
            OP_NW_CX2: begin
                mul_a = r_cnt;
                mul_b = r_prod[63:32];
            end
            OP_NW_VLO: begin
                mul_a = r_v[31:0];
            end
            OP_NW_VHI: begin
                mul_a = {2'b00, r_v[61:32]};
            end
            OP_CL_LO: begin
                mul_a = r_interval[31:0];
            end
            OP_CL_HI: begin
                mul_a = {16'd0, r_interval[47:32]};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Newton and control-law arithmetic on registered products
    assign v_next   = (NEWTON_THREE - r_prod) >> 2;
    assign inv_full = r_acc + {r_prod[31:0], 32'd0};
    assign cl_base  = i_cmd.cl_from_now ? r_in.now_ticks : r_next_drop;
    assign cl_part  = cl_base + {32'd0, r_prod[63:32]};
    assign cl_sum   = r_acc + r_prod;

    // Configuration and CoDel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= TARGET_RESET;
            r_interval    <= INTERVAL_RESET;
            r_min_backlog <= MIN_BACKLOG_RESET;
            r_dropping    <= 1'b0;
            r_first_above <= 64'd0;
            r_next_drop   <= 64'd0;
            r_cnt         <= 32'd0;
            r_last        <= 32'd0;
            r_inv         <= '0;
            r_follow_up   <= FU_NONE;
            r_verdict     <= VERDICT_DELIVER;
            r_above       <= 1'b0;
            r_recent      <= 1'b0;
            r_ge          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET:      r_target      <= i_cfg_data;
                    CFG_INTERVAL:    r_interval    <= i_cfg_data;
                    CFG_MIN_BACKLOG: r_min_backlog <= i_cfg_data[15:0];
                    default:         ;
                endcase
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_verdict <= VERDICT_DELIVER;
                end
                OP_EVAL: begin
                    if (below) begin
                        r_first_above <= 64'd0;
                        r_above       <= 1'b0;
                    end else if (r_first_above == 64'd0) begin
                        r_first_above <= fa_armed;
                        r_above       <= 1'b0;
                    end else begin
                        r_above <= now_after_fa;
                    end
                    r_recent <= since_next < drop_window;
                    r_ge     <= ge_next;
                end
                OP_EMPTY: begin
                    r_dropping  <= 1'b0;
                    r_follow_up <= FU_NONE;
                    r_verdict   <= VERDICT_EMPTY;
                end
                OP_LEAVE: begin
                    r_dropping  <= 1'b0;
                    r_follow_up <= FU_NONE;
                end
                OP_CLR_FU: begin
                    r_follow_up <= FU_NONE;
                end
                OP_ENTER: begin
                    r_dropping  <= 1'b1;
                    r_follow_up <= FU_ENTRY;
                    r_verdict   <= VERDICT_DROP;
                    r_cnt       <= cnt_enter;
                    r_last      <= cnt_enter;
                    if (!r_recent) begin
                        r_inv <= U32_ONES[RECIP_SQRT_BITS-1:0];
                    end
                end
                OP_STEP_DROP: begin
                    r_cnt       <= r_cnt + 32'd1;
                    r_follow_up <= FU_LOOP;
                    r_verdict   <= VERDICT_DROP;
                end
                OP_NW_FIN: begin
                    r_inv <= inv_full[INV_LSB +: RECIP_SQRT_BITS];
                end
                OP_CL_FIN: begin
                    r_next_drop <= cl_sum;
                end
                OP_CMP: begin
                    r_ge <= ge_next;
                end
                default: ;
            endcase
        end
    end

    // Input capture, products and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_in <= i_in_data;
        end
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.op == OP_NW_V) begin
            r_v <= v_next[61:0];
        end
        if (i_cmd.op == OP_NW_VHI) begin
            r_acc <= r_prod;
        end else if (i_cmd.op == OP_CL_HI) begin
            r_acc <= cl_part;
        end
        if (i_cmd.op == OP_OUT) begin
            r_out.verdict      <= r_verdict;
            r_out.in_drop_mode <= r_dropping;
            r_out.drop_count   <= r_cnt;
        end
    end

    // Status to the controller
    assign o_stat.queue_empty = r_in.queue_empty;
    assign o_stat.above       = r_above;
    assign o_stat.recent      = r_recent;
    assign o_stat.ge_next     = r_ge;
    assign o_stat.dropping    = r_dropping;
    assign o_stat.follow_up   = r_follow_up;

    assign o_out_data = r_out;

    `CDD_ASSERT_NEXT(a_enter_mode, i_clk, i_rst_n, i_cmd.op == OP_ENTER, r_dropping && (r_follow_up == FU_ENTRY) && (r_last == r_cnt), "entry drop did not set mode and last count")
    `CDD_ASSERT_NEXT(a_step_count, i_clk, i_rst_n, i_cmd.op == OP_STEP_DROP, (r_cnt == $past(r_cnt) + 32'd1) && (r_follow_up == FU_LOOP), "loop drop did not advance count")
    `CDD_ASSERT_NEXT(a_empty_clear, i_clk, i_rst_n, i_cmd.op == OP_EMPTY, !r_dropping && (r_follow_up == FU_NONE) && (r_verdict == VERDICT_EMPTY), "empty queue did not clear mode")

endmodule

`default_nettype wire

>>> rtl/cdd_ctrl.sv
// Controller of the CoDel drop decision: sequences datapath operations
// and owns the packet and result handshakes. Depends on cdd_pkg.
`default_nettype none
`include "codel_drop_decision_assert.svh"

module cdd_ctrl
    import cdd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_then_cl;
    logic        n_then_cl;
    logic        r_cl_now;
    logic        n_cl_now;
    logic        r_out_valid;
    logic        n_out_valid;

    // State and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_then_cl   <= 1'b0;
            r_cl_now    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_then_cl   <= n_then_cl;
            r_cl_now    <= n_cl_now;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath command
    always_comb begin
        n_state           = r_state;
        n_then_cl         = r_then_cl;
        n_cl_now          = r_cl_now;
        o_cmd.op          = OP_NONE;
        o_cmd.cl_from_now = r_cl_now;
        o_in_stall        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.queue_empty) begin
                    o_cmd.op = OP_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_EVAL;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (i_stat.follow_up)
                    FU_ENTRY: begin
                        o_cmd.op = OP_CLR_FU;
                    end
                    FU_LOOP: begin
                        if (!i_stat.above) begin
                            o_cmd.op = OP_LEAVE;
                        end else begin
                            // continue the drop loop from the last drop time
                            o_cmd.op = OP_CLR_FU;
                            n_cl_now = 1'b0;
                            n_state  = S_CL_LO;
                        end
                    end
                    default: begin
                        if (i_stat.dropping) begin
                            if (!i_stat.above) begin
                                o_cmd.op = OP_LEAVE;
                            end else if (i_stat.ge_next) begin
                                o_cmd.op  = OP_STEP_DROP;
                                n_then_cl = 1'b0;
                                n_state   = S_NW_XX;
                            end else begin
                                o_cmd.op = OP_CLR_FU;
                            end
                        end else if (i_stat.above) begin
                            // enter dropping mode, schedule from now
                            o_cmd.op = OP_ENTER;
                            n_cl_now = 1'b1;
                            if (i_stat.recent) begin
                                n_then_cl = 1'b1;
                                n_state   = S_NW_XX;
                            end else begin
                                n_state = S_CL_LO;
                            end
                        end else begin
                            o_cmd.op = OP_CLR_FU;
                        end
                    end
                endcase
            end
            S_NW_XX: begin
                o_cmd.op = OP_NW_XX;
                n_state  = S_NW_CX2;
            end
            S_NW_CX2: begin
                o_cmd.op = OP_NW_CX2;
                n_state  = S_NW_V;
            end
            S_NW_V: begin
                o_cmd.op = OP_NW_V;
                n_state  = S_NW_VLO;
            end
            S_NW_VLO: begin
                o_cmd.op = OP_NW_VLO;
                n_state  = S_NW_VHI;
            end
            S_NW_VHI: begin
                o_cmd.op = OP_NW_VHI;
                n_state  = S_NW_FIN;
            end
            S_NW_FIN: begin
                o_cmd.op = OP_NW_FIN;
                n_state  = r_then_cl ? S_CL_LO : S_DONE;
            end
            S_CL_LO: begin
                o_cmd.op = OP_CL_LO;
                n_state  = S_CL_HI;
            end
            S_CL_HI: begin
                o_cmd.op = OP_CL_HI;
                n_state  = S_CL_FIN;
            end
            S_CL_FIN: begin
                o_cmd.op = OP_CL_FIN;
                n_state  = r_cl_now ? S_DONE : S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = S_RECHECK;
            end
            S_RECHECK: begin
                n_state = S_DONE;
                if (i_stat.ge_next) begin
                    o_cmd.op  = OP_STEP_DROP;
                    n_then_cl = 1'b0;
                    n_state   = S_NW_XX;
                end
            end
            S_DONE: begin
                // hand the word over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.op == OP_OUT) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    `CDD_ASSERT(a_out_no_overwrite, i_clk, i_rst_n, (o_cmd.op == OP_OUT) |-> (!r_out_valid || !i_out_stall), "output word overwritten while stalled")
    `CDD_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_EVAL, "accepted word not evaluated")
    `CDD_ASSERT_NEXT(a_newton_then_law, i_clk, i_rst_n, (r_state == S_NW_FIN) && r_then_cl, r_state == S_CL_LO, "entry Newton step not followed by control law")

endmodule

`default_nettype wire

>>> rtl/codel_drop_decision.sv
// Top level of the CoDel drop decision block: controller plus datapath.
// Depends on cdd_pkg, cdd_ctrl and cdd_datapath.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in_data  (t_in_word)
//   out      output     o_out_valid / i_out_stall  o_out_data (t_out_word)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An empty queue goes straight to output; delivering or leaving dropping mode
// adds the decision; an entry drop adds the control law, after a Newton step
// if the last run was recent; a drop in dropping mode, a Newton step; a loop
// drop, the control law, a recheck and, on a further drop, a Newton step. One
// shared 32x32 multiplier: a Newton step uses it four times, the law twice.
// Synchronous active-low reset clears the CoDel state and loads the default
// configuration. One output register holds a finished word; the next word is
// taken and worked on while it waits, and is parked until the register frees.
`default_nettype none

module codel_drop_decision
    import cdd_pkg::*;
#(
    parameter int unsigned RECIP_SQRT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_we;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    cdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cdd_datapath #(
        .RECIP_SQRT_BITS (RECIP_SQRT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/tb_codel_drop_decision.sv
// Self-checking testbench for the CoDel drop decision block.
// Holds its own model of the CoDel state, drives packet words under random
// stalls and compares every verdict word. Depends on cdd_pkg and the RTL.
`default_nettype none

module tb_codel_drop_decision
    import cdd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROOT_BITS = 16;
    localparam logic [63:0] MAX48     = 64'h0000_FFFF_FFFF_FFFF;
    // Index with no register behind it
    localparam logic [1:0]  CFG_SPARE = 2'd3;
    // Cycles to let pass once the block has gone quiet
    localparam int          QUIET_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_word    in_word = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_TARGET;
    logic [47:0] cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_data;
    logic        o_cfg_ready;

    codel_drop_decision #(
        .RECIP_SQRT_BITS(ROOT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Model copy of the configuration and the CoDel state
    logic [63:0]          cfg_target   = 64'(TARGET_RESET);
    logic [63:0]          cfg_interval = 64'(INTERVAL_RESET);
    logic [15:0]          cfg_min      = MIN_BACKLOG_RESET;
    logic                 st_dropping    = 1'b0;
    logic [63:0]          st_first_above = '0;
    logic [63:0]          st_next_drop   = '0;
    logic [31:0]          st_count       = '0;
    logic [31:0]          st_last_count  = '0;
    logic [ROOT_BITS-1:0] st_inv_root    = '0;
    t_follow_up           st_follow      = FU_NONE;

    t_in_word  packet_q[$];
    t_out_word verdict_q[$];
    int        n_queued = 0;
    int        n_accepted = 0;
    int        n_seen = 0;
    int        n_mismatch = 0;
    int        n_drop_seen = 0;
    int        n_empty_seen = 0;
    int        n_settings = 0;
    logic      in_fire = 1'b0;
    logic      calm = 1'b0;
    logic [63:0] clock_now = '0;

    // Inverse root scaled up to a Q0.32 fraction
    function automatic logic [31:0] root_q32();
        return 32'(st_inv_root) << (32 - ROOT_BITS);
    endfunction

    // One Newton step on the inverse root for the current count
    function automatic void refine_root();
        logic [63:0] x, x2, v, p;
        x  = {32'd0, root_q32()};
        x2 = (x * x) >> 32;
        v  = NEWTON_THREE - ({32'd0, st_count} * x2);
        v  = v >> 2;
        p  = v * x;
        v  = p >> 31;
        st_inv_root = ROOT_BITS'(v >> (32 - ROOT_BITS));
    endfunction

    // Next drop time: t + interval / sqrt(count)
    function automatic logic [63:0] spaced_drop_time(input logic [63:0] t);
        logic [63:0] m, hi, lo;
        m  = {32'd0, root_q32()};
        hi = cfg_interval >> 32;
        lo = cfg_interval & 64'hFFFF_FFFF;
        return t + hi * m + ((lo * m) >> 32);
    endfunction

    function automatic logic is_above(input t_in_word w);
        if (w.sojourn_ticks < cfg_target || w.backlog_bytes <= cfg_min) begin
            st_first_above = '0;
            return 1'b0;
        end
        if (st_first_above == 0) begin
            st_first_above = w.now_ticks + cfg_interval;
            return 1'b0;
        end
        return w.now_ticks > st_first_above;
    endfunction

    function automatic void count_loop_drop();
        st_count  = st_count + 32'd1;
        refine_root();
        st_follow = FU_LOOP;
    endfunction

    // Verdict for one packet word, advancing the model state
    function automatic t_out_word judge_packet(input t_in_word w);
        t_out_word r;
        logic      above;
        r.verdict = VERDICT_DELIVER;
        if (w.queue_empty) begin
            st_dropping = 1'b0;
            st_follow   = FU_NONE;
            r.verdict   = VERDICT_EMPTY;
        end else begin
            above = is_above(w);
            if (st_follow == FU_ENTRY) begin
                st_follow = FU_NONE;
            end else if (st_follow == FU_LOOP) begin
                st_follow = FU_NONE;
                if (!above) begin
                    st_dropping = 1'b0;
                end else begin
                    st_next_drop = spaced_drop_time(st_next_drop);
                    if (w.now_ticks >= st_next_drop) begin
                        count_loop_drop();
                        r.verdict = VERDICT_DROP;
                    end
                end
            end else if (st_dropping) begin
                st_follow = FU_NONE;
                if (!above) begin
                    st_dropping = 1'b0;
                end else if (w.now_ticks >= st_next_drop) begin
                    count_loop_drop();
                    r.verdict = VERDICT_DROP;
                end
            end else if (above) begin
                r.verdict   = VERDICT_DROP;
                st_dropping = 1'b1;
                // Reuse the old count when the last drop run was recent
                if (w.now_ticks - st_next_drop < (cfg_interval << DROP_WINDOW_SHIFT)) begin
                    st_count = (st_count - st_last_count) | 32'd1;
                    refine_root();
                end else begin
                    st_count    = 32'd1;
                    st_inv_root = ROOT_BITS'(U32_ONES >> (32 - ROOT_BITS));
                end
                st_last_count = st_count;
                st_next_drop  = spaced_drop_time(w.now_ticks);
                st_follow     = FU_ENTRY;
            end else begin
                st_follow = FU_NONE;
            end
        end
        r.in_drop_mode = st_dropping;
        r.drop_count   = st_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch in %s at word %0d: expected %0h, got %0h",
                     what, n_seen, want, got);
    endtask

    // Drive the packet word channel from the pending queue
    always @(negedge i_clk) begin
        if (!in_valid || in_fire) begin
            if (packet_q.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
                in_word  <= packet_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    // Check result words, then predict for the word accepted at this edge
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result word %0d arrived with nothing expected", n_seen);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_data.verdict !== want.verdict)
                        report_mismatch("verdict", 64'(want.verdict),
                                        64'(o_out_data.verdict));
                    if (o_out_data.in_drop_mode !== want.in_drop_mode)
                        report_mismatch("in_drop_mode", 64'(want.in_drop_mode),
                                        64'(o_out_data.in_drop_mode));
                    if (o_out_data.drop_count !== want.drop_count)
                        report_mismatch("drop_count", 64'(want.drop_count),
                                        64'(o_out_data.drop_count));
                end
                if (o_out_data.verdict == VERDICT_DROP) n_drop_seen++;
                if (o_out_data.verdict == VERDICT_EMPTY) n_empty_seen++;
                n_seen++;
            end
            if (in_valid && !o_in_stall) begin
                verdict_q.push_back(judge_packet(in_word));
                n_accepted++;
            end
        end
        in_fire <= i_rst_n && in_valid && !o_in_stall;
    end

    task automatic offer(input logic e, input logic [47:0] s, input logic [31:0] b,
                         input logic [63:0] t);
        t_in_word w;
        w.queue_empty   = e;
        w.sojourn_ticks = s;
        w.backlog_bytes = b;
        w.now_ticks     = t;
        packet_q.push_back(w);
        n_queued++;
    endtask

    // Wait until every word is judged and checked, then let the block go quiet
    task automatic settle();
        do @(negedge i_clk); while (n_accepted != n_queued || verdict_q.size() != 0);
        repeat (QUIET_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TARGET:      cfg_target   = 64'(val);
            CFG_INTERVAL:    cfg_interval = 64'(val);
            CFG_MIN_BACKLOG: cfg_min      = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [47:0] target, input logic [47:0] interval,
                                  input logic [47:0] min_word, input logic with_spare);
        write_reg(CFG_TARGET, target);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_MIN_BACKLOG, min_word);
        if (with_spare)
            write_reg(CFG_SPARE, {$urandom, $urandom});
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly time-ordered congestion runs, some empty words and pure noise
    task automatic queue_random_words(input int n);
        int          r;
        logic [63:0] step, s, b, ra, rb;
        for (int k = 0; k < n; k++) begin
            ra = {$urandom, $urandom};
            rb = {$urandom, $urandom};
            r  = $urandom_range(0, 99);
            if (r < 6) begin
                offer(1'b1, ra[47:0], rb[31:0], {$urandom, $urandom});
            end else if (r < 12) begin
                offer(1'b0, ra[47:0], rb[31:0], {$urandom, $urandom});
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    step = cfg_interval * 17 + $urandom_range(0, 1000);
                else if (r < 25)
                    step = cfg_interval >> $urandom_range(3, 12);
                else
                    step = (cfg_interval * $urandom_range(0, 48)) / 32 + $urandom_range(0, 3);
                clock_now = clock_now + step;
                if ($urandom_range(0, 99) < 85) begin
                    s = cfg_target + $urandom_range(0, 5000);
                    if (s > MAX48) s = MAX48;
                end else begin
                    s = ra % cfg_target;
                end
                if ($urandom_range(0, 99) < 90)
                    b = 64'(cfg_min) + 1 + $urandom_range(0, 200000);
                else
                    b = $urandom_range(0, cfg_min);
                offer(1'b0, s[47:0], b[31:0], clock_now);
            end
        end
    endtask

    initial begin
        logic [63:0] tg, iv;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        n_settings = 1;

        // Directed words under the reset configuration
        offer(1'b1, MAX48[47:0], 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(1'b0, 48'd0, 32'd0, 64'd0);
        // backlog at the floor, sojourn just under target: both below
        offer(1'b0, MAX48[47:0], 32'd1514, 64'd10);
        offer(1'b0, 48'd99999, 32'hFFFF_FFFF, 64'd20);
        // arm, exactly at the window end, then past it: entry drop
        offer(1'b0, 48'd100000, 32'd1515, 64'd1000);
        offer(1'b0, 48'd100000, 32'd1515, 64'd2001000);
        offer(1'b0, 48'd100000, 32'd1515, 64'd2001001);
        offer(1'b0, 48'd200000, 32'd5000, 64'd2001002);
        offer(1'b0, 48'd200000, 32'd5000, 64'd2001003);
        // drops inside dropping mode and the drop loop
        offer(1'b0, 48'd200000, 32'd5000, 64'd10000000);
        offer(1'b0, 48'd200000, 32'd5000, 64'd40000000);
        offer(1'b0, 48'd0, 32'd5000, 64'd40000001);
        // re-arm and re-enter soon after: count carried over
        offer(1'b0, 48'd200000, 32'd5000, 64'd41000000);
        offer(1'b0, 48'd200000, 32'd5000, 64'd44000000);
        offer(1'b1, 48'd200000, 32'd5000, 64'd44000001);
        offer(1'b0, 48'd200000, 32'd5000, 64'd45000000);
        offer(1'b0, 48'd200000, 32'd5000, 64'd45000001);
        // time at the top of its range and just wrapped
        offer(1'b0, 48'd200000, 32'd5000, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(1'b0, 48'd200000, 32'd5000, 64'd0);
        // far from the last run: count restarts at one
        offer(1'b0, 48'd0, 32'd5000, 64'h8000_0000_0000_0000);
        offer(1'b0, 48'd200000, 32'd5000, 64'h8000_0000_0000_0001);
        offer(1'b0, 48'd200000, 32'd5000, 64'h8000_0000_0030_0000);
        clock_now = 64'h8000_0000_0030_0000;
        queue_random_words(150);
        settle();

        // Lowest settings
        apply_settings(48'd1, 48'd1, 48'd0, 1'b0);
        queue_random_words(150);
        settle();

        // Highest settings, time close to wrapping
        apply_settings(MAX48[47:0], MAX48[47:0], 48'hFFFF_FFFF_FFFF, 1'b0);
        clock_now = 64'hFFFF_FFFF_FFFF_FFFF - cfg_interval * 3;
        queue_random_words(120);
        settle();

        // Random mid-range settings; each phase pauses halfway for a full drain
        for (int p = 0; p < 6; p++) begin
            tg = $urandom_range(1, 50000);
            iv = tg * $urandom_range(2, 40);
            apply_settings(tg[47:0], iv[47:0],
                           {$urandom, 16'($urandom_range(0, 65535))}, p == 0);
            calm = (p == 1);
            queue_random_words(100);
            settle();
            queue_random_words(100);
            settle();
            calm = 1'b0;
        end

        if (verdict_q.size() != 0) begin
            $display("%0d expected words never arrived", verdict_q.size());
            n_mismatch += verdict_q.size();
        end
        $display("Checked %0d verdict words over %0d register settings (%0d drops, %0d empty).",
                 n_seen, n_settings, n_drop_seen, n_empty_seen);
        $display("Mismatches: %0d", n_mismatch);
        if (n_mismatch == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
